/* sv/pcpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pcpd_pkg;

	localparam int MAX_TAPS    = 64;
	localparam int MAX_FRAME   = 1024;
	localparam int SAMPLE_BITS = 16;

	localparam int TAP_AW  = $clog2(MAX_TAPS);
	localparam int TAPN_W  = $clog2(MAX_TAPS + 1);
	localparam int CNT_W   = $clog2(MAX_FRAME + 1);
	localparam int ACC_W   = 40;
	localparam int PROD_W  = 2 * SAMPLE_BITS;

	localparam int CFG_W       = 7;
	localparam int TAPS_RESET  = 64;

	// Request fields on the slave side.
	localparam int TIDX_W   = 6;
	localparam int VALUE_W  = 16;
	localparam int S_DATA_W = 24;
	localparam int S_TIDX_LO  = 0;
	localparam int S_VALUE_LO = S_TIDX_LO + TIDX_W;

	// Result fields on the master side.
	localparam int WIDX_W   = 10;
	localparam int PIDX_W   = 11;
	localparam int M_DATA_W = 104;
	localparam int M_WIDX_LO = 0;
	localparam int M_CORR_LO = M_WIDX_LO + WIDX_W;
	localparam int M_PIDX_LO = M_CORR_LO + ACC_W;
	localparam int M_PVAL_LO = M_PIDX_LO + PIDX_W;
	localparam int M_USED_W  = M_PVAL_LO + ACC_W;

	localparam logic ACTION_LOAD   = 1'b0;
	localparam logic ACTION_SAMPLE = 1'b1;

	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctrl_t;

endpackage

`default_nettype wire

/* sv/pcpd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module pcpd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* sv/pcpd_mac.sv */
`timescale 1ns / 1ps
`default_nettype none

module pcpd_mac (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  pcpd_pkg::mac_ctrl_t           ctrl,
	input  wire  signed [pcpd_pkg::SAMPLE_BITS-1:0] tap,
	input  wire  signed [pcpd_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                busy,
	output logic signed [pcpd_pkg::ACC_W-1:0]   acc
);
	import pcpd_pkg::*;

	logic signed [PROD_W-1:0] prod_s2;
	logic                     prod_v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s2 <= 1'b0;
		end else begin
			prod_v_s2 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= tap * sample;
		if (ctrl.clear) begin
			acc <= '0;
		end else if (prod_v_s2) begin
			acc <= acc + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	assign busy = prod_v_s2;

endmodule

`default_nettype wire

/* sv/preamble_correlation_peak_detector_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sliding preamble correlator with per-frame peak search.
// Slave stream: s_tuser selects a tap load (0) or a received sample (1), s_tlast marks
// the last sample of a frame. Loads write one preamble tap and give no result.
// Every sample gives one result on the master stream; m_tuser says a correlation window
// completed, m_tlast marks the frame's last result, which also carries the peak.
// The taps_in_use register is written through cfg_we / cfg_wdata; the user must write it
// only while the block idles, as the block itself does not enforce this. A sample that
// completes a window reaches the result register through one multiply-accumulate unit
// that walks the taps, one tap and one stored sample per cycle from two single-read-port
// memories, with a read and a product stage ahead of the accumulator; other samples skip it.
// The newest samples live in a circular buffer; a frame count says which are valid, so
// no clearing pass is needed at reset or at frame end.
// The result sits in an output register; the next request is taken while it waits, and
// only the write of a further result waits for m_tready.
// Reset clears the frame count, the peak, the output valid and sets taps_in_use to 64.
// Tap contents are undefined until loaded.
module preamble_correlation_peak_detector_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [pcpd_pkg::CFG_W-1:0]       cfg_wdata,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// tap_index [5:0], value [21:6]
	input  wire  [pcpd_pkg::S_DATA_W-1:0]    s_tdata,
	// action
	input  wire                              s_tuser,
	input  wire                              s_tlast,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// window_index [9:0], correlation [49:10], peak_index [60:50], peak_value [100:61]
	output logic [pcpd_pkg::M_DATA_W-1:0]    m_tdata,
	// window_valid
	output logic                             m_tuser,
	output logic                             m_tlast
);
	import pcpd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]  taps_cfg_q;
	logic [TAPN_W-1:0] n_act;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_next;
	logic [TAP_AW-1:0] wp_q;
	logic [TAP_AW-1:0] base_q;
	logic [TAPN_W-1:0] j_q;
	logic              rd_pend_s1;
	logic              win_q;
	logic              last_q;
	logic [WIDX_W-1:0] start_q;

	logic signed [ACC_W-1:0]  best_val_q;
	logic signed [PIDX_W-1:0] best_idx_q;
	logic signed [ACC_W-1:0]  nb_val;
	logic signed [PIDX_W-1:0] nb_idx;

	logic                           s_acc;
	logic                           load_acc;
	logic                           samp_acc;
	logic                           samp_store;
	logic                           samp_win;
	logic [TIDX_W-1:0]              in_tidx;
	logic signed [SAMPLE_BITS-1:0]  in_value;
	logic signed [SAMPLE_BITS-1:0]  tap_rd;
	logic signed [SAMPLE_BITS-1:0]  samp_rd;
	logic signed [ACC_W-1:0]        acc;
	logic                           mac_busy;
	mac_ctrl_t                      mac_ctrl;
	logic                           out_free;
	logic [M_DATA_W-1:0]            out_word;

	assign in_tidx  = s_tdata[S_TIDX_LO +: TIDX_W];
	assign in_value = s_tdata[S_VALUE_LO +: SAMPLE_BITS];

	always_comb begin
		if (taps_cfg_q == '0) begin
			n_act = TAPN_W'(1);
		end else if (TAPN_W'(taps_cfg_q) > TAPN_W'(MAX_TAPS)) begin
			n_act = TAPN_W'(MAX_TAPS);
		end else begin
			n_act = TAPN_W'(taps_cfg_q);
		end
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign s_acc      = s_tvalid && s_tready;
	assign load_acc   = s_acc && (s_tuser == ACTION_LOAD);
	assign samp_acc   = s_acc && (s_tuser == ACTION_SAMPLE);
	assign count_next = count_q + CNT_W'(1);
	assign samp_store = samp_acc && (count_q < CNT_W'(MAX_FRAME));
	assign samp_win   = samp_store && (count_next >= CNT_W'(n_act));
	assign out_free   = !m_tvalid || m_tready;

	assign mac_ctrl = '{clear: samp_win, valid: rd_pend_s1};

	pcpd_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_TAPS)
	) u_tap_ram (
		.clk   (clk),
		.we    (load_acc),
		.waddr (in_tidx[TAP_AW-1:0]),
		.wdata (in_value),
		.raddr (j_q[TAP_AW-1:0]),
		.rdata (tap_rd)
	);

	pcpd_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_TAPS)
	) u_line_ram (
		.clk   (clk),
		.we    (samp_store),
		.waddr (wp_q),
		.wdata (in_value),
		.raddr (base_q + j_q[TAP_AW-1:0]),
		.rdata (samp_rd)
	);

	pcpd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.tap    (tap_rd),
		.sample (samp_rd),
		.busy   (mac_busy),
		.acc    (acc)
	);

	// The first window of a frame always takes the peak; later ones only when strictly larger.
	always_comb begin
		nb_val = best_val_q;
		nb_idx = best_idx_q;
		if (win_q && (best_idx_q[PIDX_W-1] || acc > best_val_q)) begin
			nb_val = acc;
			nb_idx = PIDX_W'(start_q);
		end
	end

	always_comb begin
		out_word = '0;
		if (win_q) begin
			out_word[M_WIDX_LO +: WIDX_W] = start_q;
			out_word[M_CORR_LO +: ACC_W]  = acc;
		end
		if (last_q) begin
			out_word[M_PIDX_LO +: PIDX_W] = nb_idx;
			if (!nb_idx[PIDX_W-1]) begin
				out_word[M_PVAL_LO +: ACC_W] = nb_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			taps_cfg_q <= CFG_W'(TAPS_RESET);
			count_q    <= '0;
			wp_q       <= '0;
			base_q     <= '0;
			j_q        <= '0;
			rd_pend_s1 <= 1'b0;
			win_q      <= 1'b0;
			last_q     <= 1'b0;
			start_q    <= '0;
			best_val_q <= {1'b1, {(ACC_W - 1){1'b0}}};
			best_idx_q <= '1;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			m_tuser    <= 1'b0;
			m_tlast    <= 1'b0;
		end else begin
			if (cfg_we) begin
				taps_cfg_q <= cfg_wdata;
			end
			if (m_tready && (state_q != ST_FINISH)) begin
				m_tvalid <= 1'b0;
			end
			rd_pend_s1 <= (state_q == ST_MAC);

			unique case (state_q)
				ST_IDLE: begin
					if (samp_acc) begin
						win_q   <= samp_win;
						last_q  <= s_tlast;
						start_q <= WIDX_W'(count_next - CNT_W'(n_act));
						base_q  <= wp_q + TAP_AW'(1) - n_act[TAP_AW-1:0];
						j_q     <= '0;
						if (samp_store) begin
							count_q <= count_next;
							wp_q    <= wp_q + TAP_AW'(1);
						end
						state_q <= samp_win ? ST_MAC : ST_FINISH;
					end
				end
				ST_MAC: begin
					j_q <= j_q + TAPN_W'(1);
					if (j_q == n_act - TAPN_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_pend_s1 && !mac_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tuser  <= win_q;
						m_tlast  <= last_q;
						m_tdata  <= out_word;
						if (last_q) begin
							count_q    <= '0;
							best_val_q <= {1'b1, {(ACC_W - 1){1'b0}}};
							best_idx_q <= '1;
						end else begin
							best_val_q <= nb_val;
							best_idx_q <= nb_idx;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/pcpd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pcpd_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           s_tvalid,
	input wire                           s_tready,
	input wire                           s_tuser,
	input wire                           m_tvalid,
	input wire                           m_tready,
	input wire [pcpd_pkg::M_DATA_W-1:0]  m_tdata,
	input wire                           m_tuser,
	input wire                           m_tlast
);
	import pcpd_pkg::*;

	// A stalled result stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// Without a completed window the window fields read as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[M_PIDX_LO-1:0] == '0)
		else $error("window fields set without a window");

	// Peak fields are only filled on the frame's last result.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[M_USED_W-1:M_PIDX_LO] == '0)
		else $error("peak fields set before frame end");

	// A frame without a window reports no peak value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tdata[M_PIDX_LO+PIDX_W-1]
			|-> m_tdata[M_USED_W-1:M_PVAL_LO] == '0)
		else $error("peak value given without a peak");

	// A tap load never produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACTION_LOAD) && !m_tvalid |=> !m_tvalid)
		else $error("tap load produced a result");

endmodule

bind preamble_correlation_peak_detector_unit pcpd_checker u_pcpd_checker (.*);

`default_nettype wire

/* dv/tb_preamble_correlation_peak_detector_unit.sv */
`timescale 1ns / 1ps

module tb_preamble_correlation_peak_detector_unit;

	import pcpd_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 80;
	localparam longint CORR_MAX = 64'sd549755813887;
	localparam longint CORR_MIN = -CORR_MAX - 64'sd1;

	typedef struct packed {
		bit                      action;
		bit [TIDX_W-1:0]         tap;
		bit signed [VALUE_W-1:0] value;
		bit                      last;
	} stream_req_t;

	typedef struct packed {
		bit              window_valid;
		bit [WIDX_W-1:0] window_index;
		bit [ACC_W-1:0]  correlation;
		bit              frame_done;
		bit [PIDX_W-1:0] peak_index;
		bit [ACC_W-1:0]  peak_value;
	} corr_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	stream_req_t  request_fifo[$];
	corr_result_t results_due[$];

	// Predictor state: preamble taps, delay line, frame position and running peak.
	bit signed [VALUE_W-1:0] preamble[MAX_TAPS];
	bit signed [VALUE_W-1:0] delay_line[MAX_TAPS];
	int                      frame_count = 0;
	longint                  peak_corr = CORR_MIN;
	int                      peak_start = -1;
	bit [CFG_W-1:0]          taps_reg = CFG_W'(TAPS_RESET);

	int mismatches = 0;
	int cycle_count = 0;
	bit req_taken = 1'b0;
	int burst_left = 1;
	int gap_left = 0;
	int ready_hold = 0;

	preamble_correlation_peak_detector_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic int clamp_taps(input bit [CFG_W-1:0] v);
		if (v < 1)
			return 1;
		if (v > MAX_TAPS)
			return MAX_TAPS;
		return int'(v);
	endfunction

	function automatic void clear_frame();
		foreach (delay_line[k])
			delay_line[k] = '0;
		frame_count = 0;
		peak_corr = CORR_MIN;
		peak_start = -1;
	endfunction

	// Advances the correlator by one accepted request and queues the result it owes.
	function automatic void run_correlator(input stream_req_t req);
		corr_result_t res;
		longint acc;
		int n;
		int start;
		res = '0;
		if (req.action == ACTION_LOAD) begin
			preamble[req.tap] = req.value;
			return;
		end
		if (frame_count < MAX_FRAME) begin
			n = clamp_taps(taps_reg);
			for (int k = MAX_TAPS - 1; k > 0; k--)
				delay_line[k] = delay_line[k - 1];
			delay_line[0] = req.value;
			frame_count++;
			if (frame_count >= n) begin
				acc = 0;
				for (int j = 0; j < n; j++)
					acc += longint'(preamble[j]) * longint'(delay_line[n - 1 - j]);
				if (acc > CORR_MAX)
					acc = CORR_MAX;
				if (acc < CORR_MIN)
					acc = CORR_MIN;
				start = frame_count - n;
				res.window_valid = 1'b1;
				res.window_index = start[WIDX_W-1:0];
				res.correlation = acc[ACC_W-1:0];
				if (peak_start < 0 || acc > peak_corr) begin
					peak_corr = acc;
					peak_start = start;
				end
			end
		end
		if (req.last) begin
			res.frame_done = 1'b1;
			if (peak_start < 0) begin
				res.peak_index = '1;
			end else begin
				res.peak_index = peak_start[PIDX_W-1:0];
				res.peak_value = peak_corr[ACC_W-1:0];
			end
			clear_frame();
		end
		results_due.push_back(res);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// Driver, request side: a request leaves the queue at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			run_correlator(request_fifo.pop_front());
			req_taken = 1'b1;
		end
	end

	// Driver, launch side: holds a request until taken, then sends in bursts with gaps.
	always @(negedge clk) begin
		logic [S_DATA_W-1:0] word;
		if (arst_n && (!s_tvalid || req_taken)) begin
			req_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (request_fifo.size() > 0) begin
				word = '0;
				word[S_TIDX_LO +: TIDX_W] = request_fifo[0].tap;
				word[S_VALUE_LO +: VALUE_W] = request_fifo[0].value;
				s_tdata <= word;
				s_tuser <= request_fifo[0].action;
				s_tlast <= request_fifo[0].last;
				s_tvalid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					case ($urandom_range(0, 9))
						0, 1, 2, 3: gap_left = 0;
						4, 5, 6, 7: gap_left = $urandom_range(1, 4);
						8: gap_left = $urandom_range(5, 30);
						default: gap_left = $urandom_range(30, 90);
					endcase
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure: long open stretches, short hiccups and long stalls.
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else begin
			case ($urandom_range(0, 7))
				0, 1, 2: begin
					m_tready <= 1'b1;
					ready_hold = $urandom_range(1, 200);
				end
				3, 4: begin
					m_tready <= 1'b0;
					ready_hold = $urandom_range(0, 3);
				end
				5: begin
					m_tready <= 1'b0;
					ready_hold = $urandom_range(20, 90);
				end
				default: begin
					m_tready <= 1'b1;
					ready_hold = $urandom_range(0, 4);
				end
			endcase
		end
	end

	// Monitor: each result is checked against the oldest one owed.
	always @(posedge clk) begin
		corr_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				report_mismatch("unrequested result", m_tdata[63:0], '0);
			end else begin
				want = results_due.pop_front();
				if (m_tuser !== want.window_valid)
					report_mismatch("window_valid", m_tuser, want.window_valid);
				if (m_tdata[M_WIDX_LO +: WIDX_W] !== want.window_index)
					report_mismatch("window_index", m_tdata[M_WIDX_LO +: WIDX_W],
						want.window_index);
				if (m_tdata[M_CORR_LO +: ACC_W] !== want.correlation)
					report_mismatch("correlation", m_tdata[M_CORR_LO +: ACC_W], want.correlation);
				if (m_tlast !== want.frame_done)
					report_mismatch("frame_done", m_tlast, want.frame_done);
				if (m_tdata[M_PIDX_LO +: PIDX_W] !== want.peak_index)
					report_mismatch("peak_index", m_tdata[M_PIDX_LO +: PIDX_W], want.peak_index);
				if (m_tdata[M_PVAL_LO +: ACC_W] !== want.peak_value)
					report_mismatch("peak_value", m_tdata[M_PVAL_LO +: ACC_W], want.peak_value);
			end
		end
	end

	function automatic bit [VALUE_W-1:0] random_value();
		case ($urandom_range(0, 15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return '0;
			default: return VALUE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic void queue_load(input bit [TIDX_W-1:0] tap,
			input bit [VALUE_W-1:0] value, input bit last);
		request_fifo.push_back('{ACTION_LOAD, tap, value, last});
	endfunction

	function automatic void queue_sample(input bit [VALUE_W-1:0] value, input bit last);
		request_fifo.push_back('{ACTION_SAMPLE, TIDX_W'($urandom_range(0, 63)), value, last});
	endfunction

	// Mostly whole frames of random content; some too short for a window, some left open,
	// and stray tap loads mixed in.
	task automatic queue_random_frames(input int count, input int n);
		int made;
		int len;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(1, n);
			else
				len = $urandom_range(n, 3 * n + 8);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 11) == 0) begin
					queue_load(TIDX_W'($urandom_range(0, MAX_TAPS - 1)), random_value(),
						1'($urandom_range(0, 1)));
					made++;
				end
				queue_sample(random_value(), k == len - 1 && $urandom_range(0, 7) != 0);
				made++;
			end
		end
	endtask

	// Waits until every request has been taken and every result has come back,
	// then lets the longest window computation run out.
	task automatic settle();
		while (request_fifo.size() != 0 || results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_taps_reg(input bit [CFG_W-1:0] v);
		settle();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		taps_reg = v;
	endtask

	initial begin
		foreach (preamble[k])
			preamble[k] = '0;
		clear_frame();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Every tap gets written before any window can read it.
		for (int k = 0; k < MAX_TAPS; k++)
			queue_load(TIDX_W'(k), (k == 0) ? 16'h8000 : (k == 1) ? 16'h7FFF : random_value(),
				k % 5 == 0);

		// Reset tap count: a three-sample frame completes no window.
		queue_sample(16'h7FFF, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h0000, 1'b1);

		// One tap: a later equal correlation must not move the peak.
		write_taps_reg(1);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h7FFF, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h0005, 1'b1);
		queue_sample(16'hFFFF, 1'b1);
		// A tap load inside a frame, carrying a stray frame end.
		queue_sample(16'h0007, 1'b0);
		queue_load('0, 16'h0003, 1'b1);
		queue_sample(16'h0007, 1'b0);
		queue_sample(16'h0007, 1'b1);

		// A tap count of zero behaves as one.
		write_taps_reg(0);
		queue_sample(16'h0002, 1'b0);
		queue_sample(16'hFFFE, 1'b1);

		// Largest positive sum for four taps, then windows that take in 0x7FFF samples.
		write_taps_reg(4);
		for (int k = 0; k < 4; k++)
			queue_load(TIDX_W'(k), 16'h8000, 1'b0);
		for (int k = 0; k < 4; k++)
			queue_sample(16'h8000, 1'b0);
		queue_sample(16'h7FFF, 1'b0);
		queue_sample(16'h7FFF, 1'b1);

		// A frame longer than the block keeps: the tail samples complete no window.
		write_taps_reg(1);
		for (int k = 0; k < MAX_FRAME + 6; k++)
			queue_sample(random_value(), k == MAX_FRAME + 5);

		write_taps_reg(127);
		queue_random_frames(60, MAX_TAPS);
		write_taps_reg(3);
		queue_random_frames(60, 3);
		write_taps_reg(1);
		queue_random_frames(50, 1);
		write_taps_reg(17);
		queue_random_frames(60, 17);
		write_taps_reg(64);
		queue_random_frames(60, MAX_TAPS);
		write_taps_reg(8);
		queue_random_frames(60, 8);
		write_taps_reg(100);
		queue_random_frames(40, MAX_TAPS);
		write_taps_reg(5);
		queue_random_frames(60, 5);
		write_taps_reg(0);
		queue_random_frames(30, 1);

		settle();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

endmodule
